// File: hw/rtl/afst_pkg.sv
// ----------------------------------------------------------------------------
// afst_pkg
// Shared types, command and register codes and defaults for the affine flat
// span texturer.
// ----------------------------------------------------------------------------
`default_nettype none

package afst_pkg;

	// Design defaults for the top-level parameters.
	localparam int FLAT_ADDR_BITS_DEF = 12;
	localparam int LIGHT_LEVELS_DEF   = 32;

	// Fixed field widths.
	localparam int ADDR_W  = 22;
	localparam int POS_W   = 32;
	localparam int LVL_W   = 5;
	localparam int CFG_W   = 22;
	localparam int INDEX_W = 3;

	// Mode register bits.
	localparam int MODE_TRANSLATE_BIT = 0;
	localparam int MODE_BLEND_BIT     = 1;
	localparam int MODE_HOLES_BIT     = 2;
	localparam int MODE_RIPPLE_BIT    = 3;

	// Command codes carried by an input beat.
	typedef enum logic [2:0] {
		CMD_FLAT_WR  = 3'd0,
		CMD_CMAP_WR  = 3'd1,
		CMD_TRANS_WR = 3'd2,
		CMD_BLEND_WR = 3'd3,
		CMD_START    = 3'd4,
		CMD_PIXEL    = 3'd5
	} cmd_e;

	// Configuration register indexes.
	typedef enum logic [INDEX_W-1:0] {
		REG_MODE      = 3'd0,
		REG_X_SHIFT   = 3'd1,
		REG_Y_SHIFT   = 3'd2,
		REG_Y_MASK    = 3'd3,
		REG_SHIFT_UP  = 3'd4,
		REG_TRANS_IDX = 3'd5
	} reg_e;

	// Configuration register file.
	typedef struct packed {
		logic [3:0]  mode;
		logic [4:0]  x_shift;
		logic [4:0]  y_shift;
		logic [21:0] y_mask;
		logic [4:0]  shift_up;
		logic [7:0]  transparent_index;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		mode:              4'd0,
		x_shift:           5'd26,
		y_shift:           5'd20,
		y_mask:            22'd4032,
		shift_up:          5'd10,
		transparent_index: 8'd255
	};

	// Per-beat payload that travels down the lookup pipeline.
	typedef struct packed {
		logic             pix;
		logic             wr_cmap;
		logic             wr_trans;
		logic             wr_blend;
		logic [15:0]      waddr;
		logic [7:0]       wdata;
		logic [LVL_W-1:0] lvl;
		logic [7:0]       bg;
	} beat_t;

endpackage

`default_nettype wire

// File: hw/rtl/afst_fetch.sv
// ----------------------------------------------------------------------------
// afst_fetch
// Span position registers, texel address generation and the flat memory.
// Produces the first pipeline stage with the fetched texel.
// ----------------------------------------------------------------------------
`default_nettype none

module afst_fetch import afst_pkg::*; #(
	parameter int FLAT_ADDR_BITS = FLAT_ADDR_BITS_DEF,
	parameter int LIGHT_LEVELS   = LIGHT_LEVELS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              acc,
	input  wire cfg_t              cfg,
	input  wire logic [2:0]        command,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic [7:0]        data,
	input  wire logic [POS_W-1:0]  x_start,
	input  wire logic [POS_W-1:0]  y_start,
	input  wire logic [POS_W-1:0]  x_step,
	input  wire logic [POS_W-1:0]  y_step,
	input  wire logic [POS_W-1:0]  y_offset,
	input  wire logic [LVL_W-1:0]  light_level,
	input  wire logic [7:0]        background,
	output logic                   v_s1,
	output beat_t                  beat_s1,
	output logic [7:0]             texel_s1
);

	localparam int FLAT_DEPTH = 1 << FLAT_ADDR_BITS;
	localparam int CMAP_DEPTH = LIGHT_LEVELS * 256;
	localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LIGHT_LEVELS - 1);

	logic [7:0] flat_mem [FLAT_DEPTH];

	logic [POS_W-1:0] pos_x_q, pos_y_q, step_x_q, step_y_q;
	logic [LVL_W-1:0] span_level_q;

	logic [POS_W-1:0]          texel_word;
	logic [FLAT_ADDR_BITS-1:0] texel_addr;
	logic [POS_W-1:0]          y_base;
	logic                      flat_wr;
	beat_t                     beat_in;
	cmd_e                      cmd;

	assign cmd = cmd_e'(command);

	// Texel index from the current positions, truncated to the flat size.
	assign texel_word = ((pos_y_q >> cfg.y_shift) & {10'd0, cfg.y_mask})
		| (pos_x_q >> cfg.x_shift);
	assign texel_addr = texel_word[FLAT_ADDR_BITS-1:0];

	// Ripple mode offsets the start row before the shift up.
	assign y_base = cfg.mode[MODE_RIPPLE_BIT] ? (y_start + y_offset) : y_start;

	assign flat_wr = acc && (cmd == CMD_FLAT_WR)
		&& ((32'(address) >> FLAT_ADDR_BITS) == 32'd0);

	// Build the beat that follows the texel down the pipeline.
	always_comb begin
		beat_in          = '0;
		beat_in.pix      = (cmd == CMD_PIXEL);
		beat_in.wr_cmap  = (cmd == CMD_CMAP_WR) && (32'(address) < 32'(CMAP_DEPTH));
		beat_in.wr_trans = (cmd == CMD_TRANS_WR) && (32'(address) < 32'd256);
		beat_in.wr_blend = (cmd == CMD_BLEND_WR) && (32'(address) < 32'd65536);
		beat_in.waddr    = address[15:0];
		beat_in.wdata    = data;
		beat_in.lvl      = span_level_q;
		beat_in.bg       = background;
	end

	// Span state: start latches shifted positions, a pixel advances them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			step_x_q     <= '0;
			step_y_q     <= '0;
			span_level_q <= '0;
		end else if (acc) begin
			case (cmd)
				CMD_START: begin
					pos_x_q  <= x_start << cfg.shift_up;
					pos_y_q  <= y_base << cfg.shift_up;
					step_x_q <= x_step << cfg.shift_up;
					step_y_q <= y_step << cfg.shift_up;
					if (light_level > LVL_TOP) begin
						span_level_q <= LVL_TOP;
					end else begin
						span_level_q <= light_level;
					end
				end
				CMD_PIXEL: begin
					pos_x_q <= pos_x_q + step_x_q;
					pos_y_q <= pos_y_q + step_y_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
		end
	end

	// Flat memory: one write and one registered read per cycle while the pipeline advances.
	always_ff @(posedge clk) begin
		if (flat_wr) begin
			flat_mem[address[FLAT_ADDR_BITS-1:0]] <= data;
		end
		if (en) begin
			texel_s1 <= flat_mem[texel_addr];
			beat_s1  <= beat_in;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/afst_color.sv
// ----------------------------------------------------------------------------
// afst_color
// Holes test, translation, colormap and blend lookups. Each table is a
// memory written at the same stage that reads it, so program order holds.
// ----------------------------------------------------------------------------
`default_nettype none

module afst_color import afst_pkg::*; #(
	parameter int LIGHT_LEVELS = LIGHT_LEVELS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire cfg_t       cfg,
	input  wire logic       v_s1,
	input  wire beat_t      beat_s1,
	input  wire logic [7:0] texel_s1,
	output logic            res_valid,
	output logic [7:0]      res_pixel
);

	localparam int CMAP_DEPTH     = LIGHT_LEVELS * 256;
	localparam int CMAP_ADDR_BITS = $clog2(CMAP_DEPTH);

	logic [7:0] trans_mem [256];
	logic [7:0] cmap_mem  [CMAP_DEPTH];
	logic [7:0] blend_mem [65536];

	logic       v_s2, v_s3, v_s4;
	beat_t      beat_s2, beat_s3, beat_s4;
	logic       hole_s2, hole_s3, hole_s4;
	logic [7:0] texel_s2;
	logic [7:0] trans_rd_s2;
	logic [7:0] cmap_rd_s3;
	logic [7:0] cmap_s4;
	logic [7:0] blend_rd_s4;
	logic [7:0] color_s2;
	logic       hole_s1;

	assign hole_s1  = cfg.mode[MODE_HOLES_BIT] && (texel_s1 == cfg.transparent_index);
	assign color_s2 = cfg.mode[MODE_TRANSLATE_BIT] ? trans_rd_s2 : texel_s2;

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1 to 2: translation table.
	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s1 && beat_s1.wr_trans) begin
				trans_mem[beat_s1.waddr[7:0]] <= beat_s1.wdata;
			end
			trans_rd_s2 <= trans_mem[texel_s1];
			texel_s2    <= texel_s1;
			hole_s2     <= hole_s1;
			beat_s2     <= beat_s1;
		end
	end

	// Stage 2 to 3: colormap bank of the span's light level.
	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s2 && beat_s2.wr_cmap) begin
				cmap_mem[CMAP_ADDR_BITS'(beat_s2.waddr)] <= beat_s2.wdata;
			end
			cmap_rd_s3 <= cmap_mem[CMAP_ADDR_BITS'({beat_s2.lvl, color_s2})];
			hole_s3    <= hole_s2;
			beat_s3    <= beat_s2;
		end
	end

	// Stage 3 to 4: blend table indexed by color and background.
	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s3 && beat_s3.wr_blend) begin
				blend_mem[beat_s3.waddr] <= beat_s3.wdata;
			end
			blend_rd_s4 <= blend_mem[{cmap_rd_s3, beat_s3.bg}];
			cmap_s4     <= cmap_rd_s3;
			hole_s4     <= hole_s3;
			beat_s4     <= beat_s3;
		end
	end

	// Final pixel selection.
	assign res_valid = v_s4 && beat_s4.pix;

	always_comb begin
		if (hole_s4) begin
			res_pixel = beat_s4.bg;
		end else if (cfg.mode[MODE_BLEND_BIT]) begin
			res_pixel = blend_rd_s4;
		end else begin
			res_pixel = cmap_s4;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/afst_outbuf.sv
// ----------------------------------------------------------------------------
// afst_outbuf
// Output register with a one-entry skid stage. The pipeline advances
// whenever the skid stage is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module afst_outbuf (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       res_valid,
	input  wire logic [7:0] res_pixel,
	input  wire logic       pixel_stall,
	output logic            pixel_valid,
	output logic [7:0]      pixel,
	output logic            en
);

	logic       skid_v_q;
	logic [7:0] skid_pixel_q;

	assign en = !skid_v_q;

	// A result lands in the output register when it is free or being taken,
	// otherwise in the skid stage, which then holds the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid  <= 1'b0;
			pixel        <= '0;
			skid_v_q     <= 1'b0;
			skid_pixel_q <= '0;
		end else if (skid_v_q) begin
			if (!pixel_stall) begin
				pixel    <= skid_pixel_q;
				skid_v_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (!pixel_valid || !pixel_stall) begin
				pixel_valid <= 1'b1;
				pixel       <= res_pixel;
			end else begin
				skid_v_q     <= 1'b1;
				skid_pixel_q <= res_pixel;
			end
		end else if (!pixel_stall) begin
			pixel_valid <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/affine_flat_span_texturer.sv
// ----------------------------------------------------------------------------
// affine_flat_span_texturer
// Textures a horizontal span from a power-of-two flat through translation,
// colormap and blend tables held in on-chip memories.
//
//   Channel  | Handshake               | Payload
//   ---------+-------------------------+-------------------------------------
//   item     | item_valid / item_stall | command, address, data, span fields
//   pixel    | pixel_valid/pixel_stall | pixel
//   cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One input beat per cycle while item_stall is low; a pixel passes the chain
// of four memory reads (flat, translation, colormap, blend), each one stage
// deep, and then the output register before it appears on pixel.
// Table writes are applied at the stage that reads the same table.
// Reset restores the register defaults and clears positions; the memories
// hold nothing defined until written and need no clearing pass.
// A stalled output parks one pixel in a skid stage; item_stall rises then.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_flat_span_texturer import afst_pkg::*; #(
	parameter int FLAT_ADDR_BITS = FLAT_ADDR_BITS_DEF,
	parameter int LIGHT_LEVELS   = LIGHT_LEVELS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [2:0]         command,
	input  wire logic [ADDR_W-1:0]  address,
	input  wire logic [7:0]         data,
	input  wire logic [POS_W-1:0]   x_start,
	input  wire logic [POS_W-1:0]   y_start,
	input  wire logic [POS_W-1:0]   x_step,
	input  wire logic [POS_W-1:0]   y_step,
	input  wire logic [POS_W-1:0]   y_offset,
	input  wire logic [LVL_W-1:0]   light_level,
	input  wire logic [7:0]         background,
	output logic                    pixel_valid,
	input  wire logic               pixel_stall,
	output logic [7:0]              pixel,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data
);

	cfg_t       cfg_q;
	logic       en;
	logic       acc;
	logic       v_s1;
	beat_t      beat_s1;
	logic [7:0] texel_s1;
	logic       res_valid;
	logic [7:0] res_pixel;

	assign cfg_ready  = 1'b1;
	assign item_stall = !en;
	assign acc        = item_valid && en;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_e'(cfg_index))
				REG_MODE:      cfg_q.mode              <= cfg_data[3:0];
				REG_X_SHIFT:   cfg_q.x_shift           <= cfg_data[4:0];
				REG_Y_SHIFT:   cfg_q.y_shift           <= cfg_data[4:0];
				REG_Y_MASK:    cfg_q.y_mask            <= cfg_data[21:0];
				REG_SHIFT_UP:  cfg_q.shift_up          <= cfg_data[4:0];
				REG_TRANS_IDX: cfg_q.transparent_index <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	afst_fetch #(
		.FLAT_ADDR_BITS(FLAT_ADDR_BITS),
		.LIGHT_LEVELS  (LIGHT_LEVELS)
	) u_fetch (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.acc        (acc),
		.cfg        (cfg_q),
		.command    (command),
		.address    (address),
		.data       (data),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_step     (x_step),
		.y_step     (y_step),
		.y_offset   (y_offset),
		.light_level(light_level),
		.background (background),
		.v_s1       (v_s1),
		.beat_s1    (beat_s1),
		.texel_s1   (texel_s1)
	);

	afst_color #(
		.LIGHT_LEVELS(LIGHT_LEVELS)
	) u_color (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg_q),
		.v_s1     (v_s1),
		.beat_s1  (beat_s1),
		.texel_s1 (texel_s1),
		.res_valid(res_valid),
		.res_pixel(res_pixel)
	);

	afst_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res_pixel  (res_pixel),
		.pixel_stall(pixel_stall),
		.pixel_valid(pixel_valid),
		.pixel      (pixel),
		.en         (en)
	);

endmodule

`default_nettype wire

// File: hw/rtl/afst_checker.sv
// ----------------------------------------------------------------------------
// afst_checker
// Port-level checks on the output buffering and handshakes of the span
// texturer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module afst_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_valid,
	input wire logic       item_stall,
	input wire logic       pixel_valid,
	input wire logic       pixel_stall,
	input wire logic [7:0] pixel,
	input wire logic       cfg_ready
);

	// The input side only stalls while a finished pixel waits at the output.
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> pixel_valid)
		else $error("item_stall without a pending pixel");

	// Once the waiting pixel is taken the skid entry moves up and input resumes.
	a_stall_releases: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall && !pixel_stall |=> !item_stall)
		else $error("item_stall held after the output was drained");

	// A stalled pixel beat holds its value.
	a_pixel_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
		else $error("stalled pixel beat changed");

	// Configuration writes are never refused.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid || !item_valid |-> cfg_ready)
		else $error("cfg_ready dropped");

endmodule

bind affine_flat_span_texturer afst_checker u_afst_checker (.*);

`default_nettype wire
